// ===== rtl/spe_pkg.sv =====
// Package with shared types, constants and register indexes for the pendulum step block.
`timescale 1ns / 1ps
`default_nettype none
package spe_pkg;
  localparam int WordBitsDef = 32;
  localparam int FracBitsDef = 16;
  localparam int CfgIdxBits  = 3;

  localparam logic [CfgIdxBits-1:0] RegMass      = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegStiffness = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegRestLen   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegGravity   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegRate      = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegInitX     = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegInitY     = 3'd6;

  localparam logic [30:0] MassReset     = 31'd65536;
  localparam logic [30:0] StiffReset    = 31'd65536;
  localparam logic [30:0] RestLenReset  = 31'd65536;
  localparam logic [31:0] GravityReset  = 32'sd642253;
  localparam logic [9:0]  RateReset     = 10'd100;
  localparam logic [31:0] InitXReset    = 32'sd131072;
  localparam logic [31:0] InitYReset    = 32'sd131072;

  typedef struct packed {
    logic start;
    logic sqrt;
  } spe_unit_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/spe_if.sv =====
// Valid/ready channel interfaces for the pendulum step block.
`timescale 1ns / 1ps
`default_nettype none
interface spe_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface spe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_x;
  logic [31:0] new_y;
  logic [31:0] step_number;
  modport source (output valid, output new_x, output new_y, output step_number, input ready);
  modport sink (input valid, input new_x, input new_y, input step_number, output ready);
endinterface

interface spe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/spring_pendulum_euler_step.sv =====
// Top level of the elastic pendulum step block: registers, sequencer and datapath.
// Sequence: once a request is accepted, the block takes a square root, then seven wide
// divisions on the shared bit-serial unit, and then presents the result.
// Flow: the next request waits until the result has been taken. Reset: asynchronous,
// active low; registers take their reset values, position the initial position,
// velocity and step count zero.
`timescale 1ns / 1ps
`default_nettype none
module spring_pendulum_euler_step
  import spe_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spe_in_if.sink    in_if,
  spe_out_if.source out_if,
  spe_cfg_if.sink   cfg_if
);
  localparam int W  = WordBitsDef;
  localparam int XW = 64;
  localparam logic [XW-1:0] WMaxMag = XW'((65'd1 << (W - 1)) - 65'd1);

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StSqrt  = 12'b000000000010,
    StForce = 12'b000000000100,
    StFx    = 12'b000000001000,
    StFy    = 12'b000000010000,
    StAx    = 12'b000000100000,
    StAy    = 12'b000001000000,
    StGrav  = 12'b000010000000,
    StPx    = 12'b000100000000,
    StPy    = 12'b001000000000,
    StDone  = 12'b010000000000,
    StOut   = 12'b100000000000
  } st_e;

  st_e st_q;
  logic [30:0] mass_q, stiff_q, rest_q;
  logic [31:0] grav_q, initx_q, inity_q;
  logic [9:0]  rate_q;
  logic signed [XW-1:0] px_q, py_q, vx_q, vy_q, f_q, fx_q, fy_q;
  logic [XW-1:0] r_q;
  logic [31:0] steps_q;
  logic [31:0] ox_q, oy_q;
  logic        wait_q, wait_d, out_valid_q;

  spe_unit_ctl_t   uctl;
  logic [127:0]    unum;
  logic [XW-1:0]   uden, ures;
  logic            ubusy, uover;
  logic [XW-1:0]   qsat;

  spe_divsqrt #(.NumBits(128), .DenBits(XW)) u_unit (
    .clk_i, .rst_ni, .ctl_i(uctl), .num_i(unum), .den_i(uden),
    .busy_o(ubusy), .res_o(ures), .over_o(uover)
  );

  function automatic logic [XW-1:0] mag(input logic signed [XW-1:0] v);
    mag = v[XW-1] ? XW'(-v) : v;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [XW-1:0] v);
    logic [XW-1:0] m;
    m = mag(v);
    mag32 = m[31:0];
  endfunction

  function automatic logic signed [XW-1:0] from_mag(input logic neg, input logic [XW-1:0] m);
    if (m > WMaxMag) from_mag = neg ? -$signed(WMaxMag) - XW'(1) : $signed(WMaxMag);
    else from_mag = neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [XW-1:0] sadd(input logic signed [XW-1:0] a,
                                               input logic signed [XW-1:0] b);
    logic signed [XW:0] s;
    s = {a[XW-1], a} + {b[XW-1], b};
    if (s > $signed({1'b0, WMaxMag})) sadd = $signed(WMaxMag);
    else if (s < -$signed({1'b0, WMaxMag}) - $signed((XW + 1)'(1)))
      sadd = -$signed(WMaxMag) - XW'(1);
    else sadd = s[XW-1:0];
  endfunction

  function automatic logic signed [XW-1:0] sx32(input logic [31:0] v);
    sx32 = {{(XW-32){v[31]}}, v};
  endfunction

  logic [XW-1:0] rate_w;
  logic [30:0]   mass_n;
  logic [9:0]    rate_n;
  logic [40:0]   mr_w;
  assign rate_n = (rate_q == 10'd0) ? 10'd1 : rate_q;
  assign mass_n = (mass_q == 31'd0) ? 31'd1 : mass_q;
  assign rate_w = XW'(rate_n);
  assign mr_w = 41'(mass_n) * 41'(rate_n);
  assign qsat = uover ? '1 : ures;

  logic signed [XW-1:0] px_sel, py_sel;

  logic signed [XW-1:0] d_w;
  assign d_w = sadd($signed(r_q), -$signed(XW'(rest_q)));

  // Operand magnitudes are truncated to 32 bits, so each product is one 32x32 multiplication.
  logic [63:0] prod_a, prod_b;
  logic [31:0] pa, pb, py_m;
  assign py_m = mag32(py_q);
  always_comb begin
    prod_a = 64'(pa) * 64'(pb);
    prod_b = 64'(py_m) * 64'(py_m);
  end

  always_comb begin
    pa = '0; pb = '0;
    px_sel = sadd('0, sx32(initx_q)); py_sel = sadd('0, sx32(inity_q));
    unique case (st_q)
      StSqrt:  begin pa = mag32(px_q); pb = mag32(px_q); end
      StForce: begin pa = {1'b0, stiff_q}; pb = mag32(d_w); end
      StFx:    begin pa = mag32(f_q); pb = mag32(px_q); end
      StFy:    begin pa = mag32(f_q); pb = mag32(py_q); end
      default: ;
    endcase
  end

  always_comb begin
    unique case (st_q) inside
      StIdle:  wait_d = in_if.valid && !out_valid_q;
      StForce: wait_d = 1'b1;
      StFx, StFy, StAx, StAy, StGrav, StPx: wait_d = !ubusy && !wait_q;
      default: wait_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; wait_q <= 1'b0; out_valid_q <= 1'b0;
      mass_q <= MassReset; stiff_q <= StiffReset; rest_q <= RestLenReset;
      grav_q <= GravityReset; rate_q <= RateReset; initx_q <= InitXReset; inity_q <= InitYReset;
      px_q <= sadd('0, sx32(InitXReset)); py_q <= sadd('0, sx32(InitYReset));
      vx_q <= '0; vy_q <= '0; steps_q <= '0;
      r_q <= '0; f_q <= '0; fx_q <= '0; fy_q <= '0; ox_q <= '0; oy_q <= '0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          RegMass:      mass_q  <= cfg_if.data[30:0];
          RegStiffness: stiff_q <= cfg_if.data[30:0];
          RegRestLen:   rest_q  <= cfg_if.data[30:0];
          RegGravity:   grav_q  <= cfg_if.data;
          RegRate:      rate_q  <= cfg_if.data[9:0];
          RegInitX:     initx_q <= cfg_if.data;
          RegInitY:     inity_q <= cfg_if.data;
          default: ;
        endcase
      end
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      wait_q <= wait_d;
      unique case (st_q)
        StIdle: if (in_if.valid && !out_valid_q) begin
          if (in_if.restart) begin
            px_q <= px_sel; py_q <= py_sel; vx_q <= '0; vy_q <= '0; steps_q <= '0;
          end
          st_q <= StSqrt;
        end
        StSqrt: if (!ubusy && !wait_q) begin
          r_q <= (ures > WMaxMag) ? WMaxMag : ures;
          st_q <= StForce;
        end
        StForce: begin
          f_q <= from_mag(d_w[XW-1], prod_a >> FracBits);
          st_q <= StFx;
        end
        StFx: if (!ubusy && !wait_q) begin
          fx_q <= (r_q == '0) ? '0 : from_mag(f_q[XW-1] == px_q[XW-1], qsat);
          st_q <= StFy;
        end
        StFy: if (!ubusy && !wait_q) begin
          fy_q <= (r_q == '0) ? '0 : from_mag(f_q[XW-1] == py_q[XW-1], qsat);
          st_q <= StAx;
        end
        StAx: if (!ubusy && !wait_q) begin
          vx_q <= sadd(vx_q, from_mag(fx_q[XW-1], qsat));
          st_q <= StAy;
        end
        StAy: if (!ubusy && !wait_q) begin
          vy_q <= sadd(vy_q, from_mag(fy_q[XW-1], qsat));
          st_q <= StGrav;
        end
        StGrav: if (!ubusy && !wait_q) begin
          vy_q <= sadd(vy_q, from_mag(grav_q[31], qsat));
          st_q <= StPx;
        end
        StPx: if (!ubusy && !wait_q) begin
          px_q <= sadd(px_q, from_mag(vx_q[XW-1], qsat));
          st_q <= StPy;
        end
        StPy: if (!ubusy && !wait_q) begin
          py_q <= sadd(py_q, from_mag(vy_q[XW-1], qsat));
          st_q <= StDone;
        end
        StDone: begin
          steps_q <= steps_q + 32'd1;
          ox_q <= px_q[31:0]; oy_q <= py_q[31:0];
          st_q <= StOut;
        end
        StOut: begin
          out_valid_q <= 1'b1; st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // Unit launches: each state presents its operands and raises start on entry, from the registered wait_q.
  logic [127:0] l_num;
  logic [XW-1:0] l_den;
  logic          l_start, l_sqrt;
  always_comb begin
    l_start = wait_q; l_sqrt = 1'b0; l_num = '0; l_den = XW'(1);
    unique case (st_q)
      StSqrt: begin l_sqrt = 1'b1; l_num = 128'(prod_a) + 128'(prod_b); end
      StFx:   begin l_num = 128'(prod_a); l_den = (r_q == '0) ? XW'(1) : r_q; end
      StFy:   begin l_num = 128'(prod_a); l_den = (r_q == '0) ? XW'(1) : r_q; end
      StAx:   begin l_num = 128'(mag(fx_q)) << FracBits; l_den = XW'(mr_w); end
      StAy:   begin l_num = 128'(mag(fy_q)) << FracBits; l_den = XW'(mr_w); end
      StGrav: begin l_num = 128'(mag(sx32(grav_q))); l_den = rate_w; end
      StPx:   begin l_num = 128'(mag(vx_q)); l_den = rate_w; end
      StPy:   begin l_num = 128'(mag(vy_q)); l_den = rate_w; end
      default: l_start = 1'b0;
    endcase
  end

  always_comb begin
    uctl.start = l_start;
    uctl.sqrt = l_sqrt;
  end
  assign unum = l_num;
  assign uden = l_den;

  assign in_if.ready = (st_q == StIdle) && !out_valid_q;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_q;
  assign out_if.new_x = ox_q;
  assign out_if.new_y = oy_q;
  assign out_if.step_number = steps_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> st_q == StIdle)
    else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.new_x))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ubusy |-> !in_if.ready)
    else $error("accept while unit busy");
`endif
endmodule
`default_nettype wire

// ===== rtl/spe_divsqrt.sv =====
// Shared radix-2 unit computing wide quotients and integer square roots one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module spe_divsqrt
  import spe_pkg::*;
#(
  parameter int NumBits = 128,
  parameter int DenBits = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spe_unit_ctl_t      ctl_i,
  input  wire logic [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0] den_i,
  output logic                    busy_o,
  output logic [DenBits-1:0]      res_o,
  output logic                    over_o
);
  localparam int CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] num_q, num_d;
  logic [DenBits+1:0] rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [DenBits-1:0] res_q, res_d;
  logic               over_q, over_d;
  logic               sqrt_q, sqrt_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [DenBits+1:0] shifted, trial;
  logic               fits;

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; res_d = res_q;
    over_d = over_q; sqrt_d = sqrt_q; cnt_d = cnt_q; busy_d = busy_q;
    if (sqrt_q) begin
      shifted = {rem_q[DenBits-1:0], num_q[NumBits-1 -: 2]};
      trial = {res_q, 2'b01};
    end else begin
      shifted = {rem_q[DenBits:0], num_q[NumBits-1]};
      trial = {2'b00, den_q};
    end
    fits = shifted >= trial;
    if (ctl_i.start) begin
      num_d = num_i; den_d = den_i; rem_d = '0; res_d = '0; over_d = 1'b0;
      sqrt_d = ctl_i.sqrt; busy_d = 1'b1;
      cnt_d = ctl_i.sqrt ? CntBits'(NumBits / 2) : CntBits'(NumBits);
    end else if (busy_q) begin
      num_d = sqrt_q ? {num_q[NumBits-3:0], 2'b00} : {num_q[NumBits-2:0], 1'b0};
      if (res_q[DenBits-1]) over_d = 1'b1;
      rem_d = fits ? shifted - trial : shifted;
      res_d = {res_q[DenBits-2:0], fits};
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
    res_q <= res_d; over_q <= over_d; sqrt_q <= sqrt_d;
  end

  assign busy_o = busy_q;
  assign res_o = res_q;
  assign over_o = over_q && !sqrt_q;
endmodule
`default_nettype wire
